FILE: hw/rtl/cllc_pkg.sv
package cllc_pkg;

    // geometry register indexes
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT        = 1'b1;

    localparam logic [5:0] SPT_RESET = 6'h3F;
    localparam logic [7:0] HC_RESET  = 8'hFF;

    // operation codes
    localparam logic FUNC_CHS2LBA = 1'b0;
    localparam logic FUNC_LBA2CHS = 1'b1;

    // divider pipeline shape
    localparam int QW       = 32;
    localparam int BPS      = 4;
    localparam int HALF     = QW / BPS;
    localparam int NSTG     = 2 * HALF;
    localparam int JQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;

    typedef struct packed {
        logic        func;
        logic [31:0] lba_in;
        logic [7:0]  chs_head_in;
        logic [7:0]  chs_sector_in;
        logic [7:0]  chs_cylinder_in;
    } t_in_item;

    typedef struct packed {
        logic signed [24:0] lba_out;
        logic [7:0]         chs_head_out;
        logic [7:0]         chs_sector_out;
        logic [7:0]         chs_cylinder_out;
        logic               geometry_error;
    } t_out_item;

    typedef struct packed {
        logic [5:0] spt;
        logic [7:0] hc;
    } t_geom;

    typedef struct packed {
        logic        func;
        logic [31:0] lba;
        logic [9:0]  cyl;
        logic [5:0]  sec;
        logic [7:0]  head;
    } t_job;

    typedef struct packed {
        logic        vld;
        logic        func;
        logic [31:0] a;
        logic [7:0]  rem1;
        logic [7:0]  rem2;
        logic [24:0] prod;
        logic [9:0]  cyl;
        logic [5:0]  sec;
        logic [7:0]  head;
    } t_stage;

    typedef struct packed {
        logic [31:0] a;
        logic [7:0]  rem;
    } t_dv;

    // four restoring division steps, quotient bits shift in at the bottom
    function automatic t_dv div_step(input logic [31:0] a, input logic [7:0] rem,
                                     input logic [7:0] d);
        t_dv        res;
        logic [31:0] q;
        logic [7:0]  r;
        logic [8:0]  t;
        q = a;
        r = rem;
        for (int i = 0; i < BPS; i++) begin
            t = {r, q[31]};
            q = {q[30:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t[7:0];
        end
        res.a   = q;
        res.rem = r;
        return res;
    endfunction

endpackage

FILE: hw/rtl/chs_lba_address_converter_top.sv
// CHS/LBA address converter. func 0 turns a packed partition-table CHS triple
// into a 25-bit two's complement LBA, func 1 splits a 32-bit LBA into packed
// CHS using the programmed sectors per track and head count (zero geometry
// sets geometry_error). One item is taken per cycle while not full, one result
// leaves per cycle while not empty. The 16-stage divider pipeline (four quotient
// bits a stage, two divisions) sits between the job and result queues. Geometry
// must be written only while idle; the block itself does not enforce it.
module chs_lba_address_converter_top
    import cllc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_geom     r_geom;
    logic      w_job_vld, w_job_rdy, w_res_vld, w_res_rdy;
    t_job      w_job;
    t_out_item w_res;

    // geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.spt <= SPT_RESET;
            r_geom.hc  <= HC_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_SECTORS_PER_TRACK: r_geom.spt <= i_cfg_data[5:0];
                REG_HEAD_COUNT:        r_geom.hc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cllc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .o_job_vld (w_job_vld),
        .o_job     (w_job),
        .i_job_rdy (w_job_rdy)
    );

    cllc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_job_vld (w_job_vld),
        .i_job     (w_job),
        .o_job_rdy (w_job_rdy),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_res_rdy (w_res_rdy)
    );

    cllc_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_res_vld),
        .i_data     (w_res),
        .o_rdy      (w_res_rdy),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule

FILE: hw/rtl/cllc_front.sv
module cllc_front
    import cllc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    output logic     o_job_vld,
    output t_job     o_job,
    input  logic     i_job_rdy
);
    localparam int PW = $clog2(JQ_DEPTH);

    t_job             r_mem [JQ_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    t_job             w_job;
    logic             w_wr, w_rd;

    // unpack the chs bytes into cylinder and sector
    always_comb begin
        w_job.func = i_in_item.func;
        w_job.lba  = i_in_item.lba_in;
        w_job.cyl  = {i_in_item.chs_sector_in[7:6], i_in_item.chs_cylinder_in};
        w_job.sec  = i_in_item.chs_sector_in[5:0];
        w_job.head = i_in_item.chs_head_in;
    end

    assign full      = (r_cnt == (PW+1)'(JQ_DEPTH));
    assign o_job_vld = (r_cnt != '0);
    assign o_job     = r_mem[r_rp];
    assign w_wr      = push && !full;
    assign w_rd      = o_job_vld && i_job_rdy;

    // job queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_job;
        end
    end

    // job queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end

endmodule

FILE: hw/rtl/cllc_back.sv
module cllc_back
    import cllc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geom     i_geom,
    input  logic      i_job_vld,
    input  t_job      i_job,
    output logic      o_job_rdy,
    output logic      o_res_vld,
    output t_out_item o_res,
    input  logic      i_res_rdy
);
    t_stage r_st [NSTG];
    t_stage n_st [NSTG];
    t_stage w_in;
    logic   w_en;
    logic [5:0] w_s;

    // whole pipeline moves when the last stage can drain
    assign w_en      = !r_st[NSTG-1].vld || i_res_rdy;
    assign o_job_rdy = w_en;

    always_comb begin
        w_in.vld  = i_job_vld;
        w_in.func = i_job.func;
        w_in.a    = i_job.lba;
        w_in.rem1 = '0;
        w_in.rem2 = '0;
        w_in.prod = '0;
        w_in.cyl  = i_job.cyl;
        w_in.sec  = i_job.sec;
        w_in.head = i_job.head;
    end

    // per stage: division steps, plus the forward multiply in the first two
    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        t_stage w_src;
        t_dv    w_dv;
        if (k == 0) begin : g_first
            assign w_src = w_in;
        end else begin : g_next
            assign w_src = r_st[k-1];
        end
        always_comb begin
            n_st[k] = w_src;
            if (k < HALF) begin
                w_dv         = div_step(w_src.a, w_src.rem1, {2'b00, i_geom.spt});
                n_st[k].rem1 = w_dv.rem;
            end else begin
                w_dv         = div_step(w_src.a, w_src.rem2, i_geom.hc);
                n_st[k].rem2 = w_dv.rem;
            end
            n_st[k].a = w_dv.a;
            if (k == 0) begin
                n_st[k].prod = 25'(w_src.cyl * i_geom.hc) + 25'(w_src.head);
            end else if (k == 1) begin
                n_st[k].prod = 25'(w_src.prod[18:0] * i_geom.spt) + 25'(w_src.sec)
                               - 25'd1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].vld <= 1'b0;
            end else if (w_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // pack the result item
    assign w_s = r_st[NSTG-1].rem1[5:0] + 6'd1;
    always_comb begin
        o_res = '0;
        if (r_st[NSTG-1].func == FUNC_CHS2LBA) begin
            o_res.lba_out = r_st[NSTG-1].prod;
        end else if (i_geom.spt == '0 || i_geom.hc == '0) begin
            o_res.geometry_error = 1'b1;
        end else begin
            o_res.chs_head_out     = r_st[NSTG-1].rem2;
            o_res.chs_sector_out   = {r_st[NSTG-1].a[9:8], w_s};
            o_res.chs_cylinder_out = r_st[NSTG-1].a[7:0];
        end
    end
    assign o_res_vld = r_st[NSTG-1].vld;

endmodule

FILE: hw/rtl/cllc_rq.sv
module cllc_rq
    import cllc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_out_item i_data,
    output logic      o_rdy,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);
    localparam int PW = $clog2(RQ_DEPTH);

    t_out_item     r_mem [RQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_rdy      = (r_cnt != (PW+1)'(RQ_DEPTH));
    assign empty      = (r_cnt == '0);
    assign o_out_item = r_mem[r_rp];
    assign w_wr       = i_wr && o_rdy;
    assign w_rd       = pop && !empty;

    // result storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // result pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(RQ_DEPTH)) else $error("result queue overflow");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !o_rdy) |=> i_wr) else $error("result dropped while queue full");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("result count did not advance");
`endif

endmodule

FILE: test/tb_checker.sv
module tb_checker
    import cllc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  t_in_item              i_in_item,
    input  logic                  empty,
    input  logic                  pop,
    input  t_out_item             o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0] spt;
    logic [7:0] hc;
    t_out_item  conv_q[$];
    int         fails;

    // expected conversion for one input item under the current geometry
    function automatic t_out_item convert_addr(t_in_item it);
        t_out_item   r;
        logic [31:0] cyl, v, track, c, h, s;
        r = '0;
        if (it.func == FUNC_CHS2LBA) begin
            cyl = {22'd0, it.chs_sector_in[7:6], it.chs_cylinder_in};
            v = (cyl * hc + it.chs_head_in) * spt + it.chs_sector_in[5:0];
            v = v - 32'd1;
            r.lba_out = v[24:0];
        end else if (spt == 0 || hc == 0) begin
            r.geometry_error = 1'b1;
        end else begin
            track = it.lba_in / spt;
            c = track / hc;
            h = track % hc;
            s = (it.lba_in % spt) + 32'd1;
            r.chs_head_out = h[7:0];
            r.chs_sector_out = {c[9:8], s[5:0]};
            r.chs_cylinder_out = c[7:0];
        end
        return r;
    endfunction

    assign o_fail_count = fails;
    assign o_pending = conv_q.size();

    // track geometry writes, predict on push, compare on pop
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            spt <= SPT_RESET;
            hc <= HC_RESET;
            conv_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == REG_SECTORS_PER_TRACK) spt <= i_cfg_data[5:0];
                else if (i_cfg_idx == REG_HEAD_COUNT) hc <= i_cfg_data;
            end
            if (pop && !empty) begin
                if (conv_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", o_out_item);
                end else begin
                    exp_item = conv_q.pop_front();
                    if (exp_item !== o_out_item) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp lba %h h %h s %h c %h e %b, got %h %h %h %h %b",
                                exp_item.lba_out, exp_item.chs_head_out,
                                exp_item.chs_sector_out, exp_item.chs_cylinder_out,
                                exp_item.geometry_error, o_out_item.lba_out,
                                o_out_item.chs_head_out, o_out_item.chs_sector_out,
                                o_out_item.chs_cylinder_out, o_out_item.geometry_error);
                    end
                end
            end
            if (push && !full) conv_q.push_back(convert_addr(i_in_item));
        end
    end
endmodule

FILE: test/tb_top.sv
module tb_top;
    import cllc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  push = 0;
    logic                  full;
    t_in_item              i_in_item = '0;
    logic                  empty;
    logic                  pop = 0;
    t_out_item             o_out_item;
    logic                  i_cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count, pending;
    int                    cycle_cnt = 0;
    bit                    hold_rx = 0;
    bit                    steady = 0;

    always #5 i_clk = ~i_clk;

    chs_lba_address_converter_top u_top (.*);

    tb_checker u_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random pops, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) pop <= 1'b0;
        else if (steady) pop <= 1'b1;
        else if ($urandom_range(0, 19) == 0) pop <= 1'b0;
        else pop <= ($urandom_range(0, 3) != 0);
    end

    function automatic int gap_len();
        if ($urandom_range(0, 29) == 0) return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // one transaction: present item and wait until taken, push stays up for the next
    task automatic send_item(t_in_item it, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_geom(logic [5:0] s, logic [7:0] h);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= REG_SECTORS_PER_TRACK;
        i_cfg_data <= {2'b0, s};
        @(posedge i_clk);
        i_cfg_idx <= REG_HEAD_COUNT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        it.func = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: it.lba_in = 32'hFFFF_FFFF - $urandom_range(0, 255);
            1: it.lba_in = $urandom_range(0, 4000);
            default: it.lba_in = $urandom;
        endcase
        it.chs_head_in = 8'($urandom);
        it.chs_sector_in = 8'($urandom);
        it.chs_cylinder_in = 8'($urandom);
        return it;
    endfunction

    initial begin
        t_in_item it;
        logic [5:0] spt_set[6] = '{6'd63, 6'd1, 6'd0, 6'd17, 6'd63, 6'd32};
        logic [7:0] hc_set[6]  = '{8'd255, 8'd1, 8'd16, 8'd0, 8'd128, 8'd255};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: field extremes, both operations, sector zero, wrapping cylinder
        for (int k = 0; k < 12; k++) begin
            it = '0;
            it.func = k[0] ? FUNC_LBA2CHS : FUNC_CHS2LBA;
            case (k / 2)
                0: it = it;
                1: begin it.lba_in = '1; it.chs_head_in = '1;
                         it.chs_sector_in = '1; it.chs_cylinder_in = '1; end
                2: begin it.lba_in = 32'd62; it.chs_sector_in = 8'd1; end
                3: begin it.lba_in = 32'd16065; it.chs_sector_in = 8'hC0; end
                4: begin it.lba_in = 32'h00FA_0000; it.chs_head_in = 8'd1; end
                default: begin it.lba_in = 32'hAAAA_5555; it.chs_sector_in = 8'h3F; end
            endcase
            send_item(it, 1'b0);
        end
        drain();
        // random phases across geometry settings, including zero geometry
        for (int p = 0; p < 6; p++) begin
            write_geom(spt_set[p], hc_set[p]);
            // long receiver hold-off, timed on its own
            if (p == 3) begin
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end
            if (p == 5) steady <= 1'b1;
            for (int n = 0; n < 215; n++) begin
                if (p == 2 && n == 100) drain();
                send_item(rand_item(), p == 3 || p == 5);
            end
            drain();
            steady <= 1'b0;
        end
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: chs_lba_address_converter_top.f
hw/rtl/cllc_pkg.sv
hw/rtl/cllc_front.sv
hw/rtl/cllc_back.sv
hw/rtl/cllc_rq.sv
hw/rtl/chs_lba_address_converter_top.sv
test/tb_checker.sv
test/tb_top.sv
